/* design/rawf_pkg.sv */
// ----------------------------------------------------------------------------
// rawf_pkg
// Shared codes and constants of the register ALU with flags.
// ----------------------------------------------------------------------------
package rawf_pkg;

  // Instruction codes
  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_MUL   = 4'd2,
    CMD_LSH   = 4'd3,
    CMD_RSH   = 4'd4,
    CMD_AND   = 4'd5,
    CMD_OR    = 4'd6,
    CMD_XOR   = 4'd7,
    CMD_UMULL = 4'd8,
    CMD_SMULL = 4'd9
  } cmd_e;

  // Operand selection
  typedef enum logic [1:0] {
    MODE_IMM = 2'd0,
    MODE_REG = 2'd1,
    MODE_MEM = 2'd2,
    MODE_BAD = 2'd3
  } mode_e;

  localparam int unsigned DataW   = 16;
  localparam int unsigned ResultW = 32;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned CmdW    = 4;
  localparam int unsigned ModeW   = 2;

endpackage

/* design/rawf_ram.sv */
// ----------------------------------------------------------------------------
// rawf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rawf_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/register_alu_with_flags_top.sv */
// ----------------------------------------------------------------------------
// register_alu_with_flags_top
// Register-file ALU: one instruction per transaction, 16-bit registers,
// overflow and zero flags, 16x16 long multiplies.
// ----------------------------------------------------------------------------
// Each input transaction carries one instruction. The block reads its
// operands from a register file of NUM_REGS 16-bit registers, computes a
// 32-bit result (add, subtract clamped at zero, multiply, shifts,
// logic ops, or an unsigned/signed long multiply), writes the register file
// and returns one output transaction with both result halves, the flags after
// the instruction and a bad-mode indication. Throughput is one instruction per
// clock with both channels open. The accepting edge loads the execute stage and
// launches the synchronous register-file read; the execute stage then moves its
// result into the output register once that register is free or drains.
// The register file sits in two write banks (one for the destination write,
// one for the long-multiply high-half write), each duplicated for the two read
// ports; a per-register tag records which bank holds the newest value, and
// the writes of the previous instruction are forwarded so that dependent
// instructions may follow back to back. Per-register valid bits give the
// all-zero reset at once, so the block is ready right after reset with no
// clearing pass. Register indexes are taken modulo NUM_REGS.
// ----------------------------------------------------------------------------
module register_alu_with_flags_top
  import rawf_pkg::*;
#(
  parameter int NUM_REGS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // instruction channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CmdW-1:0]     cmd_i,
  input  logic [ModeW-1:0]    mode_i,
  input  logic [IndexW-1:0]   dest_index_i,
  input  logic [IndexW-1:0]   src_index_i,
  input  logic [IndexW-1:0]   high_index_i,
  input  logic [DataW-1:0]    immediate_i,
  input  logic [DataW-1:0]    memory_value_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DataW-1:0]    result_low_o,
  output logic [DataW-1:0]    result_high_o,
  output logic                overflow_flag_o,
  output logic                zero_flag_o,
  output logic                bad_mode_o
);

  localparam int AddrW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  // Reduce a 4-bit register index modulo NUM_REGS (at most eight subtracts).
  function automatic logic [AddrW-1:0] reg_slot(logic [IndexW-1:0] idx);
    logic [IndexW:0] v;
    v = {1'b0, idx};
    for (int i = 0; i < 8; i++) begin
      if (int'(v) >= NUM_REGS) begin
        v = v - (IndexW+1)'(NUM_REGS);
      end
    end
    return AddrW'(v);
  endfunction

  // --------------------------------------------------------------------------
  // Handshake and stage control
  // --------------------------------------------------------------------------
  logic in_accept;
  logic s1_valid_q;
  logic advance;
  logic out_valid_q;

  // Advance the execute stage when the output register is free or drains now.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Execute-stage payload, loaded on acceptance.
  cmd_e             s1_cmd_q;
  mode_e            s1_mode_q;
  logic [AddrW-1:0] s1_rd_q;
  logic [AddrW-1:0] s1_rn_q;
  logic [AddrW-1:0] s1_rh_q;
  logic [DataW-1:0] s1_imm_q;
  logic [DataW-1:0] s1_mem_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q  <= cmd_e'(cmd_i);
      s1_mode_q <= mode_e'(mode_i);
      s1_rd_q   <= reg_slot(dest_index_i);
      s1_rn_q   <= reg_slot(src_index_i);
      s1_rh_q   <= reg_slot(high_index_i);
      s1_imm_q  <= immediate_i;
      s1_mem_q  <= memory_value_i;
    end
  end

  // --------------------------------------------------------------------------
  // Register file: bank A takes destination writes, bank B high-half writes.
  // Each bank is duplicated to serve the two read ports.
  // --------------------------------------------------------------------------
  logic [AddrW-1:0] raddr_rd;
  logic [AddrW-1:0] raddr_rn;
  logic             wa_en;
  logic             wb_en;
  logic [DataW-1:0] wa_data;
  logic [DataW-1:0] wb_data;
  logic [DataW-1:0] bank_a_rd;
  logic [DataW-1:0] bank_a_rn;
  logic [DataW-1:0] bank_b_rd;
  logic [DataW-1:0] bank_b_rn;

  // Hold the read addresses of a stalled instruction so its data stays fresh.
  assign raddr_rd = in_accept ? reg_slot(dest_index_i) : s1_rd_q;
  assign raddr_rn = in_accept ? reg_slot(src_index_i)  : s1_rn_q;

  rawf_ram #(.Width(DataW), .Depth(NUM_REGS)) u_bank_a_rd (
    .clk_i, .we_i(wa_en), .waddr_i(s1_rd_q), .wdata_i(wa_data),
    .raddr_i(raddr_rd), .rdata_o(bank_a_rd)
  );
  rawf_ram #(.Width(DataW), .Depth(NUM_REGS)) u_bank_a_rn (
    .clk_i, .we_i(wa_en), .waddr_i(s1_rd_q), .wdata_i(wa_data),
    .raddr_i(raddr_rn), .rdata_o(bank_a_rn)
  );
  rawf_ram #(.Width(DataW), .Depth(NUM_REGS)) u_bank_b_rd (
    .clk_i, .we_i(wb_en), .waddr_i(s1_rh_q), .wdata_i(wb_data),
    .raddr_i(raddr_rd), .rdata_o(bank_b_rd)
  );
  rawf_ram #(.Width(DataW), .Depth(NUM_REGS)) u_bank_b_rn (
    .clk_i, .we_i(wb_en), .waddr_i(s1_rh_q), .wdata_i(wb_data),
    .raddr_i(raddr_rn), .rdata_o(bank_b_rn)
  );

  // Per-register tags: written since reset, and newest value in bank B.
  logic [NUM_REGS-1:0] written_q;
  logic [NUM_REGS-1:0] in_b_q;
  logic [NUM_REGS-1:0] written_d;
  logic [NUM_REGS-1:0] in_b_d;

  always_comb begin
    written_d = written_q;
    in_b_d    = in_b_q;
    if (wa_en) begin
      written_d[s1_rd_q] = 1'b1;
      in_b_d[s1_rd_q]    = 1'b0;
    end
    // High half wins when both writes name the same register.
    if (wb_en) begin
      written_d[s1_rh_q] = 1'b1;
      in_b_d[s1_rh_q]    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      in_b_q    <= '0;
    end else begin
      written_q <= written_d;
      in_b_q    <= in_b_d;
    end
  end

  // Writes of the previous cycle, which the RAM reads have not seen yet.
  logic             fwd_a_en_q;
  logic             fwd_b_en_q;
  logic [AddrW-1:0] fwd_a_addr_q;
  logic [AddrW-1:0] fwd_b_addr_q;
  logic [DataW-1:0] fwd_a_data_q;
  logic [DataW-1:0] fwd_b_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_a_en_q <= 1'b0;
      fwd_b_en_q <= 1'b0;
    end else begin
      fwd_a_en_q <= wa_en;
      fwd_b_en_q <= wb_en;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_a_addr_q <= s1_rd_q;
    fwd_b_addr_q <= s1_rh_q;
    fwd_a_data_q <= wa_data;
    fwd_b_data_q <= wb_data;
  end

  function automatic logic [DataW-1:0] pick_reg(
    logic [AddrW-1:0] addr,
    logic [DataW-1:0] a_data,
    logic [DataW-1:0] b_data,
    logic             b_en,
    logic [AddrW-1:0] b_addr,
    logic [DataW-1:0] b_fwd,
    logic             a_en,
    logic [AddrW-1:0] a_addr,
    logic [DataW-1:0] a_fwd,
    logic             wr,
    logic             inb
  );
    logic [DataW-1:0] v;
    if (b_en && b_addr == addr) begin
      v = b_fwd;
    end else if (a_en && a_addr == addr) begin
      v = a_fwd;
    end else if (!wr) begin
      v = '0;
    end else if (inb) begin
      v = b_data;
    end else begin
      v = a_data;
    end
    return v;
  endfunction

  logic [DataW-1:0] val_rd;
  logic [DataW-1:0] val_rn;

  assign val_rd = pick_reg(s1_rd_q, bank_a_rd, bank_b_rd,
                           fwd_b_en_q, fwd_b_addr_q, fwd_b_data_q,
                           fwd_a_en_q, fwd_a_addr_q, fwd_a_data_q,
                           written_q[s1_rd_q], in_b_q[s1_rd_q]);
  assign val_rn = pick_reg(s1_rn_q, bank_a_rn, bank_b_rn,
                           fwd_b_en_q, fwd_b_addr_q, fwd_b_data_q,
                           fwd_a_en_q, fwd_a_addr_q, fwd_a_data_q,
                           written_q[s1_rn_q], in_b_q[s1_rn_q]);

  // --------------------------------------------------------------------------
  // Execute
  // --------------------------------------------------------------------------
  logic               is_alu;
  logic               is_long;
  logic               bad;
  logic               alu_ok;
  logic [DataW-1:0]   opa;
  logic [DataW-1:0]   opb;
  logic [ResultW-1:0] a32;
  logic signed [DataW:0]     mul_a;
  logic signed [DataW:0]     mul_b;
  logic signed [2*DataW+1:0] mul_p;
  logic [ResultW-1:0] res;
  logic               ovf_q;
  logic               zero_q;

  assign is_alu  = (s1_cmd_q <= CMD_XOR);
  assign is_long = (s1_cmd_q == CMD_UMULL) || (s1_cmd_q == CMD_SMULL);
  assign bad     = is_alu && (s1_mode_q == MODE_BAD);
  assign alu_ok  = is_alu && !bad;

  always_comb begin
    unique case (s1_mode_q)
      MODE_IMM: begin opa = val_rd; opb = s1_imm_q; end
      MODE_REG: begin opa = val_rn; opb = val_rd;   end
      MODE_MEM: begin opa = val_rd; opb = s1_mem_q; end
      MODE_BAD: begin opa = val_rd; opb = s1_mem_q; end
    endcase
  end

  assign a32 = {{(ResultW-DataW){1'b0}}, opa};

  // One shared multiplier: zero-extended for mul/umull, sign-extended for smull.
  always_comb begin
    if (is_long) begin
      mul_a = (s1_cmd_q == CMD_SMULL) ? {val_rd[DataW-1], val_rd} : {1'b0, val_rd};
      mul_b = (s1_cmd_q == CMD_SMULL) ? {val_rn[DataW-1], val_rn} : {1'b0, val_rn};
    end else begin
      mul_a = {1'b0, opa};
      mul_b = {1'b0, opb};
    end
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    res = '0;
    if (alu_ok || is_long) begin
      unique case (s1_cmd_q)
        CMD_ADD:   res = a32 + {{(ResultW-DataW){1'b0}}, opb};
        CMD_SUB:   res = (opb > opa) ? '0 : {{(ResultW-DataW){1'b0}}, opa - opb};
        CMD_MUL:   res = mul_p[ResultW-1:0];
        CMD_LSH:   res = (|opb[DataW-1:5]) ? '0 : (a32 << opb[4:0]);
        CMD_RSH:   res = (|opb[DataW-1:5]) ? '0 : (a32 >> opb[4:0]);
        CMD_AND:   res = a32 & {{(ResultW-DataW){1'b0}}, opb};
        CMD_OR:    res = a32 | {{(ResultW-DataW){1'b0}}, opb};
        CMD_XOR:   res = a32 ^ {{(ResultW-DataW){1'b0}}, opb};
        CMD_UMULL: res = mul_p[ResultW-1:0];
        CMD_SMULL: res = mul_p[ResultW-1:0];
        default:   res = '0;
      endcase
    end
  end

  assign wa_en   = advance && (alu_ok || is_long);
  assign wb_en   = advance && is_long;
  assign wa_data = res[DataW-1:0];
  assign wb_data = res[ResultW-1:DataW];

  // Flags: update only on a supported ALU instruction.
  logic flag_upd;
  logic ovf_d;
  logic zero_d;

  assign flag_upd = advance && alu_ok;
  assign ovf_d    = flag_upd ? (|res[ResultW-1:DataW]) : ovf_q;
  assign zero_d   = flag_upd ? (res == '0) : zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q  <= 1'b0;
      zero_q <= 1'b0;
    end else begin
      ovf_q  <= ovf_d;
      zero_q <= zero_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [DataW-1:0] out_low_q;
  logic [DataW-1:0] out_high_q;
  logic             out_ovf_q;
  logic             out_zero_q;
  logic             out_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_low_q  <= res[DataW-1:0];
      out_high_q <= res[ResultW-1:DataW];
      out_ovf_q  <= ovf_d;
      out_zero_q <= zero_d;
      out_bad_q  <= bad;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_low_o    = out_low_q;
  assign result_high_o   = out_high_q;
  assign overflow_flag_o = out_ovf_q;
  assign zero_flag_o     = out_zero_q;
  assign bad_mode_o      = out_bad_q;

`ifndef SYNTH
  // A high-half write only ever comes with its low-half write.
  a_long_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_en |-> wa_en)
    else $error("high-half write without destination write");

  // An instruction leaving execute shows up in the output register.
  a_adv_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("executed instruction lost before output");

  // A bad-mode result carries zero in both halves.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_mode_o) |-> (result_low_o == '0 && result_high_o == '0))
    else $error("bad-mode result not zero");

  // Flags hold across any cycle without a supported ALU instruction.
  a_flag_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !flag_upd |=> ($stable(ovf_q) && $stable(zero_q)))
    else $error("flags changed without an ALU instruction");
`endif

endmodule

/* tb/tb_register_alu_with_flags_top.sv */
// ----------------------------------------------------------------------------
// tb_register_alu_with_flags_top
// Self-checking bench for the register-file ALU with overflow and zero flags.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the register file and the flags. It
// predicts every result from each accepted instruction and compares the
// outputs field by field, in order. A directed sequence comes first. It covers
// every operation, the operand modes, the unsupported mode, unknown commands,
// long multiplies that write the high half to the destination register, and
// overflow, zero and shift-range limits. A long random phase follows, with
// random idle bursts on both channels and a quiet tail that has no idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_register_alu_with_flags_top;
  import rawf_pkg::*;

  localparam int unsigned NumRegs     = 16;
  localparam int unsigned RandomItems = 1300;
  localparam int unsigned QuietTail   = 200;
  localparam int unsigned PauseEvery  = 300;
  localparam int unsigned DrainLimit  = 5000;
  localparam int unsigned CmdMax      = (1 << CmdW) - 1;
  localparam int unsigned ModeMax     = (1 << ModeW) - 1;
  localparam int unsigned IndexMax    = (1 << IndexW) - 1;
  localparam int unsigned ShiftRange  = ResultW;

  // One instruction as it sits on the input channel
  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [ModeW-1:0]  mode;
    logic [IndexW-1:0] rd;
    logic [IndexW-1:0] rn;
    logic [IndexW-1:0] rh;
    logic [DataW-1:0]  imm;
    logic [DataW-1:0]  mem;
  } instr_t;

  // One result as it sits on the output channel
  typedef struct packed {
    logic [DataW-1:0] lo;
    logic [DataW-1:0] hi;
    logic             ovf;
    logic             zero;
    logic             bad;
  } alu_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow register file and flags, plus the queue of predicted
  // results in acceptance order.
  // --------------------------------------------------------------------------
  class alu_result_tracker;
    logic [DataW-1:0] shadow_regs [NumRegs];
    logic             ovf_bit;
    logic             zero_bit;
    alu_result_t      pending_results [$];
    int unsigned      errors;

    function new();
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      ovf_bit  = 1'b0;
      zero_bit = 1'b0;
      errors   = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Execute the instruction on the shadow state and queue its result
    function void note_instruction(instr_t ins);
      logic [ResultW-1:0] a;
      logic [ResultW-1:0] b;
      logic [ResultW-1:0] r;
      int                 sa;
      int                 sb;
      alu_result_t        e;
      int unsigned        rd;
      int unsigned        rn;
      int unsigned        rh;
      rd = ins.rd % NumRegs;
      rn = ins.rn % NumRegs;
      rh = ins.rh % NumRegs;
      e  = '0;
      r  = '0;
      if (ins.cmd <= CMD_XOR) begin
        if (ins.mode == MODE_BAD) begin
          e.bad = 1'b1;
        end else begin
          case (ins.mode)
            MODE_IMM: begin
              a = {{(ResultW-DataW){1'b0}}, shadow_regs[rd]};
              b = {{(ResultW-DataW){1'b0}}, ins.imm};
            end
            MODE_REG: begin
              a = {{(ResultW-DataW){1'b0}}, shadow_regs[rn]};
              b = {{(ResultW-DataW){1'b0}}, shadow_regs[rd]};
            end
            default: begin
              a = {{(ResultW-DataW){1'b0}}, shadow_regs[rd]};
              b = {{(ResultW-DataW){1'b0}}, ins.mem};
            end
          endcase
          case (ins.cmd)
            CMD_ADD: r = a + b;
            CMD_SUB: r = (b > a) ? '0 : a - b;
            CMD_MUL: r = a * b;
            CMD_LSH: r = (b >= ShiftRange) ? '0 : a << b;
            CMD_RSH: r = (b >= ShiftRange) ? '0 : a >> b;
            CMD_AND: r = a & b;
            CMD_OR:  r = a | b;
            default: r = a ^ b;
          endcase
          ovf_bit         = (r > {{(ResultW-DataW){1'b0}}, {DataW{1'b1}}});
          zero_bit        = (r == '0);
          shadow_regs[rd] = r[DataW-1:0];
        end
      end else if (ins.cmd == CMD_UMULL || ins.cmd == CMD_SMULL) begin
        if (ins.cmd == CMD_UMULL) begin
          r = {{(ResultW-DataW){1'b0}}, shadow_regs[rd]} *
              {{(ResultW-DataW){1'b0}}, shadow_regs[rn]};
        end else begin
          sa = int'($signed(shadow_regs[rd]));
          sb = int'($signed(shadow_regs[rn]));
          r  = ResultW'(sa * sb);
        end
        // High half goes last so it wins when both indexes match
        shadow_regs[rd] = r[DataW-1:0];
        shadow_regs[rh] = r[ResultW-1:DataW];
      end
      e.lo   = r[DataW-1:0];
      e.hi   = r[ResultW-1:DataW];
      e.ovf  = ovf_bit;
      e.zero = zero_bit;
      pending_results.push_back(e);
    endfunction

    function void report_field(string field, logic [DataW-1:0] exp_v,
                               logic [DataW-1:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch: expected %h actual %h", $time, field,
                 exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(alu_result_t got);
      alu_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none actual %h", $time, got);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      report_field("result_low", e.lo, got.lo);
      report_field("result_high", e.hi, got.hi);
      report_field("overflow_flag", DataW'(e.ovf), DataW'(got.ovf));
      report_field("zero_flag", DataW'(e.zero), DataW'(got.zero));
      report_field("bad_mode", DataW'(e.bad), DataW'(got.bad));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [CmdW-1:0]   cmd_i;
  logic [ModeW-1:0]  mode_i;
  logic [IndexW-1:0] dest_index_i;
  logic [IndexW-1:0] src_index_i;
  logic [IndexW-1:0] high_index_i;
  logic [DataW-1:0]  immediate_i;
  logic [DataW-1:0]  memory_value_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [DataW-1:0]  result_low_o;
  logic [DataW-1:0]  result_high_o;
  logic              overflow_flag_o;
  logic              zero_flag_o;
  logic              bad_mode_o;

  // Set during the final stretch: no idling on either side
  logic              quiet_tail;

  alu_result_tracker tracker;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  register_alu_with_flags_top #(
    .NUM_REGS(NumRegs)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .mode_i         (mode_i),
    .dest_index_i   (dest_index_i),
    .src_index_i    (src_index_i),
    .high_index_i   (high_index_i),
    .immediate_i    (immediate_i),
    .memory_value_i (memory_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_low_o   (result_low_o),
    .result_high_o  (result_high_o),
    .overflow_flag_o(overflow_flag_o),
    .zero_flag_o    (zero_flag_o),
    .bad_mode_o     (bad_mode_o)
  );

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  function automatic instr_t make_instr(logic [CmdW-1:0] cmd, logic [ModeW-1:0] mode,
                                        int unsigned rd, int unsigned rn,
                                        int unsigned rh, logic [DataW-1:0] imm,
                                        logic [DataW-1:0] mem);
    instr_t ins;
    ins.cmd  = cmd;
    ins.mode = mode;
    ins.rd   = IndexW'(rd);
    ins.rn   = IndexW'(rn);
    ins.rh   = IndexW'(rh);
    ins.imm  = imm;
    ins.mem  = mem;
    return ins;
  endfunction

  // Drive one instruction and hold it until the transaction completes.
  // Called right after a rising edge; all changes happen at falling edges.
  task automatic send_instr(instr_t ins);
    int unsigned gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cmd_i          <= ins.cmd;
    mode_i         <= ins.mode;
    dest_index_i   <= ins.rd;
    src_index_i    <= ins.rn;
    high_index_i   <= ins.rh;
    immediate_i    <= ins.imm;
    memory_value_i <= ins.mem;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_instruction(ins);
  endtask

  // Drop valid and hold off until every predicted result has come back or the drain limit runs out
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // Operand values that favor the interesting corners
  function automatic logic [DataW-1:0] pick_operand(logic [CmdW-1:0] cmd);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if ((cmd == CMD_LSH || cmd == CMD_RSH) && sel < 7) begin
      return DataW'($urandom_range(0, ShiftRange + 8));
    end
    case (sel)
      0:       return '0;
      1:       return '1;
      2:       return DataW'($urandom_range(0, 15));
      default: return DataW'($urandom());
    endcase
  endfunction

  function automatic instr_t random_instr();
    instr_t      ins;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      ins.cmd = CmdW'($urandom_range(CMD_SMULL + 1, CmdMax));
    end else if (sel < 25) begin
      ins.cmd = ($urandom_range(0, 1) != 0) ? CMD_UMULL : CMD_SMULL;
    end else begin
      ins.cmd = CmdW'($urandom_range(CMD_ADD, CMD_XOR));
    end
    ins.mode = ($urandom_range(0, 11) == 0) ? MODE_BAD :
               ModeW'($urandom_range(MODE_IMM, MODE_MEM));
    // Crowd the indexes now and then to stress back-to-back dependencies
    if ($urandom_range(0, 2) == 0) begin
      ins.rd = IndexW'($urandom_range(0, 3));
      ins.rn = IndexW'($urandom_range(0, 3));
      ins.rh = IndexW'($urandom_range(0, 3));
    end else begin
      ins.rd = IndexW'($urandom_range(0, IndexMax));
      ins.rn = IndexW'($urandom_range(0, IndexMax));
      ins.rh = IndexW'($urandom_range(0, IndexMax));
    end
    ins.imm = pick_operand(ins.cmd);
    ins.mem = pick_operand(ins.cmd);
    return ins;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver side: random stall bursts until the quiet tail
  // --------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Check each result transaction at the edge that completes it
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_result({result_low_o, result_high_o, overflow_flag_o,
                            zero_flag_o, bad_mode_o});
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    tracker        = new();
    quiet_tail     = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    cmd_i          = '0;
    mode_i         = '0;
    dest_index_i   = '0;
    src_index_i    = '0;
    high_index_i   = '0;
    immediate_i    = '0;
    memory_value_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed: load registers, then hit each operation and corner
    send_instr(make_instr(CMD_OR,    MODE_IMM, 1,  0,  0,  16'hFFFF, 16'h0000));
    send_instr(make_instr(CMD_OR,    MODE_IMM, 2,  0,  0,  16'h0001, 16'h0000));
    // carry out of the low half: overflow, register wraps to zero
    send_instr(make_instr(CMD_ADD,   MODE_IMM, 1,  0,  0,  16'h0001, 16'h0000));
    send_instr(make_instr(CMD_ADD,   MODE_MEM, 1,  0,  0,  16'h0000, 16'hFFFF));
    // subtract below zero clamps
    send_instr(make_instr(CMD_SUB,   MODE_IMM, 2,  0,  0,  16'h0005, 16'h0000));
    send_instr(make_instr(CMD_SUB,   MODE_REG, 2,  1,  0,  16'h0000, 16'h0000));
    send_instr(make_instr(CMD_MUL,   MODE_REG, 2,  1,  0,  16'h0000, 16'h0000));
    send_instr(make_instr(CMD_LSH,   MODE_IMM, 1,  0,  0,  16'd31,   16'h0000));
    send_instr(make_instr(CMD_OR,    MODE_IMM, 3,  0,  0,  16'h8001, 16'h0000));
    // shift of the full width or more yields zero
    send_instr(make_instr(CMD_LSH,   MODE_IMM, 3,  0,  0,  16'd32,   16'h0000));
    send_instr(make_instr(CMD_OR,    MODE_IMM, 3,  0,  0,  16'h8001, 16'h0000));
    send_instr(make_instr(CMD_RSH,   MODE_IMM, 3,  0,  0,  16'd15,   16'h0000));
    send_instr(make_instr(CMD_RSH,   MODE_MEM, 3,  0,  0,  16'h0000, 16'hFFFF));
    send_instr(make_instr(CMD_OR,    MODE_IMM, 4,  0,  0,  16'hA5A5, 16'h0000));
    send_instr(make_instr(CMD_AND,   MODE_IMM, 4,  0,  0,  16'h0F0F, 16'h0000));
    send_instr(make_instr(CMD_XOR,   MODE_REG, 4,  4,  0,  16'h0000, 16'h0000));
    // unsupported mode leaves everything alone
    send_instr(make_instr(CMD_ADD,   MODE_BAD, 15, 15, 15, 16'hFFFF, 16'hFFFF));
    send_instr(make_instr(CMD_OR,    MODE_IMM, 15, 0,  0,  16'h8000, 16'h0000));
    send_instr(make_instr(CMD_OR,    MODE_MEM, 0,  0,  0,  16'h0000, 16'h7FFF));
    send_instr(make_instr(CMD_UMULL, MODE_IMM, 15, 0,  7,  16'h0000, 16'h0000));
    send_instr(make_instr(CMD_OR,    MODE_IMM, 8,  0,  0,  16'hFFFF, 16'h0000));
    send_instr(make_instr(CMD_SMULL, MODE_IMM, 8,  0,  9,  16'h0000, 16'h0000));
    // long multiply ignores mode; high half wins on a shared register
    send_instr(make_instr(CMD_SMULL, MODE_BAD, 9,  9,  9,  16'h0000, 16'h0000));
    send_instr(make_instr(CmdW'(CMD_SMULL + 1), MODE_IMM, 1, 2, 3, 16'hFFFF, 16'hFFFF));
    send_instr(make_instr(CmdW'(CmdMax), MODE_REG, 4, 5, 6, 16'h0000, 16'h0000));

    drain_results();

    // Random phase; pause for a full drain every few hundred instructions
    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i == RandomItems - QuietTail) quiet_tail = 1'b1;
      if (i != 0 && i % PauseEvery == 0) drain_results();
      send_instr(random_instr());
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (tracker.pending() != 0) begin
      $display("%0t: results missing: expected %0d more actual 0", $time,
               tracker.pending());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("register_alu_with_flags_top verification clean");
    end else begin
      $display("register_alu_with_flags_top verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("register_alu_with_flags_top verification failed");
    $finish;
  end

endmodule

/* filelist.f */
design/rawf_pkg.sv
design/rawf_ram.sv
design/register_alu_with_flags_top.sv
tb/tb_register_alu_with_flags_top.sv
